@@ hdl/hpva_pkg.sv @@
package hpva_pkg;

  localparam int ANGLE_BINS  = 10;
  localparam int R_BINS      = 10;
  localparam int PAIRS       = ANGLE_BINS * ANGLE_BINS;
  localparam int STORE_DEPTH = PAIRS * R_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAIR_W      = $clog2(PAIRS);
  localparam int RBIN_W      = $clog2(R_BINS);

  localparam int PT_W        = 16;
  localparam int NORM_W      = 16;
  localparam int BIN_INDEX_W = 10;
  localparam int COUNT_W     = 32;
  localparam int RMAX_W      = 16;
  localparam int RSCALE_W    = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
  localparam logic [RMAX_W-1:0]    RMAX_RESET    = 16'd4096;
  localparam logic [RSCALE_W-1:0]  RSCALE_RESET  = 24'd160;

  localparam logic [CFG_IDX_W-1:0] CFG_R_MAX     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_SCALE   = 1'b1;

  localparam logic REQ_VOTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam longint Q30_ONE     = longint'(1) << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm_t;

  typedef norm_t [PAIRS-1:0] norm_tab_t;

  typedef struct packed {
    logic              valid;
    logic              below;
    logic              above;
    logic [ADDR_W-1:0] addr;
  } vote_ev_t;

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >> 30;
  endfunction

  function automatic logic signed [NORM_W-1:0] q30_to_q14(input longint v);
    longint w;
    w = v;
    if (w < 0) w = 0;
    if (w > Q30_ONE) w = Q30_ONE;
    return NORM_W'((w + 32768) >> 16);
  endfunction

  function automatic logic [2*NORM_W-1:0] turn_sincos(input logic [31:0] t);
    longint rem;
    longint x;
    longint x2;
    longint h;
    logic signed [NORM_W-1:0] s;
    logic signed [NORM_W-1:0] c;
    logic signed [NORM_W-1:0] so;
    logic signed [NORM_W-1:0] co;
    rem = longint'({34'd0, t[29:0]});
    x   = (rem * HALF_PI_Q30) >> 30;
    x2  = q30_mul(x, x);
    h = Q30_ONE - x2 / 72;
    h = Q30_ONE - q30_mul(x2, h) / 42;
    h = Q30_ONE - q30_mul(x2, h) / 20;
    h = Q30_ONE - q30_mul(x2, h) / 6;
    s = q30_to_q14(q30_mul(x, h));
    h = Q30_ONE - x2 / 90;
    h = Q30_ONE - q30_mul(x2, h) / 56;
    h = Q30_ONE - q30_mul(x2, h) / 30;
    h = Q30_ONE - q30_mul(x2, h) / 12;
    c = q30_to_q14(Q30_ONE - q30_mul(x2, h) / 2);
    case (t[31:30])
      2'd0: begin
        so = s;
        co = c;
      end
      2'd1: begin
        so = c;
        co = -s;
      end
      2'd2: begin
        so = -s;
        co = -c;
      end
      default: begin
        so = -c;
        co = s;
      end
    endcase
    return {so, co};
  endfunction

  function automatic logic signed [NORM_W-1:0] q14_mul_round(
    input logic signed [NORM_W-1:0] a,
    input logic signed [NORM_W-1:0] b
  );
    longint p;
    longint m;
    logic   neg;
    p   = longint'(a) * longint'(b);
    neg = (p < 0);
    m   = neg ? -p : p;
    m   = (m + 8192) >> 14;
    return neg ? NORM_W'(-m) : NORM_W'(m);
  endfunction

  function automatic norm_tab_t build_norm_table();
    norm_tab_t tab;
    longint unsigned tt;
    longint unsigned tp;
    logic [2*NORM_W-1:0] sct;
    logic [2*NORM_W-1:0] scp;
    logic signed [NORM_W-1:0] st;
    logic signed [NORM_W-1:0] ct;
    logic signed [NORM_W-1:0] sp;
    logic signed [NORM_W-1:0] cp;
    tab = '0;
    for (int i = 0; i < ANGLE_BINS; i++) begin
      tt  = (longint'(2 * i + 1) << 32) / (4 * ANGLE_BINS);
      sct = turn_sincos(tt[31:0]);
      st  = sct[2*NORM_W-1:NORM_W];
      ct  = sct[NORM_W-1:0];
      for (int j = 0; j < ANGLE_BINS; j++) begin
        tp  = (longint'(2 * j + 1) << 32) / (2 * ANGLE_BINS);
        scp = turn_sincos(tp[31:0]);
        sp  = scp[2*NORM_W-1:NORM_W];
        cp  = scp[NORM_W-1:0];
        tab[i * ANGLE_BINS + j].x = q14_mul_round(st, cp);
        tab[i * ANGLE_BINS + j].y = q14_mul_round(st, sp);
        tab[i * ANGLE_BINS + j].z = ct;
      end
    end
    return tab;
  endfunction

  localparam norm_tab_t NORM_TABLE = build_norm_table();

endpackage

@@ hdl/hpva_if.sv @@
interface hpva_req_if import hpva_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [PT_W-1:0]        point_x;
  logic signed [PT_W-1:0]        point_y;
  logic signed [PT_W-1:0]        point_z;
  logic        [BIN_INDEX_W-1:0] bin_index;

  modport source (output valid, req_type, point_x, point_y, point_z, bin_index,
                  input ready);
  modport sink (input valid, req_type, point_x, point_y, point_z, bin_index,
                output ready);
endinterface

interface hpva_rsp_if import hpva_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic [COUNT_W-1:0] below_count;
  logic [COUNT_W-1:0] above_count;

  modport source (output valid, bin_count, below_count, above_count, input ready);
  modport sink (input valid, bin_count, below_count, above_count, output ready);
endinterface

@@ hdl/hpva_vote_pipe.sv @@
module hpva_vote_pipe import hpva_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  point_t              point,
  input  logic [RMAX_W-1:0]   r_max,
  input  logic [RSCALE_W-1:0] r_scale,
  output vote_ev_t            ev,
  output logic                busy
);

  logic                 running;
  logic [PAIR_W-1:0]    pair_idx;
  logic [ADDR_W-1:0]    pair_base;
  point_t               pt;
  norm_t                norm;

  logic                 s0_valid;
  logic [ADDR_W-1:0]    s0_base;
  logic signed [31:0]   prod_x;
  logic signed [31:0]   prod_y;
  logic signed [31:0]   prod_z;

  logic                 s1_valid;
  logic [ADDR_W-1:0]    s1_base;
  logic signed [33:0]   s1_r;

  logic                 s2_valid;
  logic [ADDR_W-1:0]    s2_base;
  logic                 s2_below;
  logic                 s2_above;
  logic [53:0]          s2_prod;

  logic                 r_below;
  logic                 r_above;
  logic [23:0]          rb;
  logic [RBIN_W-1:0]    rbin;

  assign norm    = NORM_TABLE[pair_idx];
  assign r_below = s1_r[33] || (s1_r == '0);
  assign r_above = !s1_r[33] && (s1_r[32:0] >= {3'b000, r_max, 14'd0});
  assign rb      = s2_prod[53:30];
  assign rbin    = (rb > 24'(R_BINS - 1)) ? RBIN_W'(R_BINS - 1) : rb[RBIN_W-1:0];
  assign busy    = running || s0_valid || s1_valid || s2_valid || ev.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      ev       <= '0;
    end else begin
      if (start) begin
        running <= 1'b1;
      end else if (running && (pair_idx == PAIR_W'(PAIRS - 1))) begin
        running <= 1'b0;
      end
      s0_valid <= running;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      ev.valid <= s2_valid;
      ev.below <= s2_below;
      ev.above <= s2_above;
      ev.addr  <= s2_base + ADDR_W'(rbin);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pt        <= point;
      pair_idx  <= '0;
      pair_base <= '0;
    end else if (running) begin
      pair_idx  <= pair_idx + 1'b1;
      pair_base <= pair_base + ADDR_W'(R_BINS);
    end
    s0_base  <= pair_base;
    prod_x   <= pt.x * norm.x;
    prod_y   <= pt.y * norm.y;
    prod_z   <= pt.z * norm.z;
    s1_base  <= s0_base;
    s1_r     <= 34'(prod_x) + 34'(prod_y) + 34'(prod_z);
    s2_base  <= s1_base;
    s2_below <= r_below;
    s2_above <= !r_below && r_above;
    s2_prod  <= s1_r[29:0] * r_scale;
  end

endmodule

@@ hdl/hpva_store.sv @@
module hpva_store import hpva_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  vote_ev_t           ev,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [COUNT_W-1:0] rd_data,
  output logic               busy,
  output logic               wr_pend
);

  logic [COUNT_W-1:0] mem [STORE_DEPTH];

  logic               clearing;
  logic [ADDR_W-1:0]  clr_addr;
  logic               upd_valid;
  logic [ADDR_W-1:0]  upd_addr;
  logic               ev_bin;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  assign ev_bin    = ev.valid && !ev.below && !ev.above;
  assign mem_re    = ev_bin || rd_en;
  assign mem_raddr = ev_bin ? ev.addr : rd_addr;
  assign mem_we    = clearing || upd_valid;
  assign mem_waddr = clearing ? clr_addr : upd_addr;
  assign mem_wdata = clearing ? '0 :
                     (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
  assign busy      = clearing;
  assign wr_pend   = upd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      upd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      upd_valid <= ev_bin;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr <= ev.addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule

@@ hdl/hough_plane_vote_accumulator_unit.sv @@
// Hough plane voting accumulator with a 1000-entry histogram of 32-bit counts.
// Words enter on the req channel and leave on the rsp channel, both with a
// valid/ready handshake. A vote word carries a point; it produces no rsp word
// and sweeps all 100 theta-phi pairs, one pair per cycle through a four-stage
// multiply and binning pipeline that ends in a read-modify-write of the vote
// memory. A vote keeps req.ready low until the pipeline has drained and its
// last memory update is written. A read word returns one bin and both miss
// counters; acceptance moves the state to ST_READ, which loads the rsp word,
// and req.ready returns in the cycle it is loaded, so reads do not overlap.
// The rsp output register holds a finished word while the receiver stalls; a
// read that completes behind a stalled word waits in place until it is taken.
// The cfg port writes r_max (index 0) and r_scale (index 1) and is meant for
// use while the block is idle. Synchronous reset restores the register
// defaults, zeroes the miss counters and starts a clearing pass over all
// 1000 vote memory entries, during which req.ready stays low.
module hough_plane_vote_accumulator_unit import hpva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  hpva_req_if.sink              req,
  hpva_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_VOTE = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t               state;
  logic [RMAX_W-1:0]    r_max;
  logic [RSCALE_W-1:0]  r_scale;
  logic [COUNT_W-1:0]   below_total;
  logic [COUNT_W-1:0]   above_total;
  logic                 rd_oob;

  logic                 accept;
  logic                 vote_start;
  logic                 rd_en;
  logic                 load_rsp;
  point_t               point;
  vote_ev_t             ev;
  logic                 ev_bin;
  logic                 pipe_busy;
  logic                 store_busy;
  logic                 wr_pend;
  logic [COUNT_W-1:0]   rd_data;

  assign req.ready  = (state == ST_IDLE) && !store_busy;
  assign accept     = req.valid && req.ready;
  assign vote_start = accept && (req.req_type == REQ_VOTE);
  assign rd_en      = accept && (req.req_type == REQ_READ);
  assign load_rsp   = (state == ST_READ) && (!rsp.valid || rsp.ready);
  assign point      = '{x: req.point_x, y: req.point_y, z: req.point_z};
  assign ev_bin     = ev.valid && !ev.below && !ev.above;

  hpva_vote_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .start   (vote_start),
    .point   (point),
    .r_max   (r_max),
    .r_scale (r_scale),
    .ev      (ev),
    .busy    (pipe_busy)
  );

  hpva_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ev      (ev),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(req.bin_index)),
    .rd_data (rd_data),
    .busy    (store_busy),
    .wr_pend (wr_pend)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      r_max       <= RMAX_RESET;
      r_scale     <= RSCALE_RESET;
      below_total <= '0;
      above_total <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_R_MAX:   r_max   <= cfg_data[RMAX_W-1:0];
          CFG_R_SCALE: r_scale <= cfg_data[RSCALE_W-1:0];
          default: ;
        endcase
      end
      if (ev.valid && ev.below && (below_total != COUNT_MAX)) begin
        below_total <= below_total + 1'b1;
      end
      if (ev.valid && ev.above && (above_total != COUNT_MAX)) begin
        above_total <= above_total + 1'b1;
      end
      if (load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (vote_start) begin
            state <= ST_VOTE;
          end else if (rd_en) begin
            state <= ST_READ;
          end
        end
        ST_VOTE: begin
          if (!pipe_busy && !wr_pend) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (load_rsp) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_oob <= (req.bin_index >= BIN_INDEX_W'(STORE_DEPTH));
    end
    if (load_rsp) begin
      rsp.bin_count   <= rd_oob ? '0 : rd_data;
      rsp.below_count <= below_total;
      rsp.above_count <= above_total;
    end
  end

  assert property (@(posedge clk) disable iff (rst) store_busy |-> !req.ready)
    else $error("request accepted during the clearing pass");

  assert property (@(posedge clk) disable iff (rst) ev.valid |-> (state == ST_VOTE))
    else $error("vote event outside a vote");

  assert property (@(posedge clk) disable iff (rst)
    (ev_bin && $past(ev_bin)) |-> (ev.addr != $past(ev.addr)))
    else $error("back-to-back updates hit the same bin");

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_READ))
    else $error("result word raised outside a read");

endmodule
